FILE: hw/rtl/profile_point_stats_table_defines.svh
`ifndef PROFILE_POINT_STATS_TABLE_DEFINES_SVH
`define PROFILE_POINT_STATS_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define PPST_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ppst assertion failed");

// Next-cycle implication, sampled on clk and off during reset.
`define PPST_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ppst assertion failed");

`endif

FILE: hw/rtl/ppst_pkg.sv
`timescale 1ns / 1ps
package ppst_pkg;

  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_RECORD   = 3'd1;
  localparam logic [2:0] OP_QUERY    = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_START    = 3'd4;
  localparam logic [2:0] OP_STOP     = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_ENABLED = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX   = 3'd3;
  localparam logic [2:0] ST_ALREADY_ON  = 3'd4;
  localparam logic [2:0] ST_NOT_ON      = 3'd5;

  // Register index of the enable register (byte address 4 * index).
  localparam logic CFG_IDX_ENABLE = 1'b0;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  point_index;
    logic [31:0] cycle_count;
    logic [2:0]  point_type;
    logic [15:0] src_line;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  result_index;
    logic [31:0] hit_total;
    logic [47:0] cyc_sum;
    logic [31:0] cyc_min;
    logic [31:0] cyc_max;
    logic [2:0]  stored_type;
    logic [15:0] stored_line;
    logic [31:0] sample_sum;
  } out_item_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [47:0] sum;
    logic [31:0] min;
    logic [31:0] max;
  } stats_t;

  typedef struct packed {
    logic [2:0]  ptype;
    logic [15:0] line;
  } type_line_t;

  localparam stats_t STATS_CLEAR = '{hits: 32'd0, sum: 48'd0, min: '1, max: 32'd0};

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic sweep_init;
    logic sweep_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic out_free;
    logic sweep_done;
  } dp_stat_t;

endpackage

FILE: hw/rtl/ppst_dp.sv
`timescale 1ns / 1ps
module ppst_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppst_pkg::ctrl_cmd_t cmd,
  output ppst_pkg::dp_stat_t  stat,
  input  ppst_pkg::in_item_t  in_data,
  input  logic                enable,
  input  logic                out_ready,
  output logic                out_valid,
  output ppst_pkg::out_item_t out_data
);
  import ppst_pkg::*;

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;

  stats_t     stats_mem [MAX_POINTS];
  type_line_t tl_mem    [MAX_POINTS];

  in_item_t   itm_r;
  stats_t     stats_rd_r;
  type_line_t tl_rd_r;
  out_item_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] sweep_ctr_r, sweep_ctr_nxt;
  logic [31:0] total_r, total_nxt;
  logic        coll_r, coll_nxt;

  logic [CMP_W-1:0]  in_idx_ext, itm_idx_ext, count_ext;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              idx_ok, reg_ok, rec_ok, sweep_we, st_we, tl_we;
  stats_t            rec_stats, st_wdata;
  out_item_t         res;
  logic [CNT_W:0]    sweep_next_cnt;

  assign in_idx_ext  = CMP_W'(in_data.point_index);
  assign itm_idx_ext = CMP_W'(itm_r.point_index);
  assign count_ext   = CMP_W'(count_r);
  assign rd_addr     = in_idx_ext[ADDR_W-1:0];
  assign idx_ok      = itm_idx_ext < count_ext;

  // Read-modify-write of one entry for a recorded sample.
  always_comb begin
    rec_stats.hits = stats_rd_r.hits + 32'd1;
    rec_stats.sum  = stats_rd_r.sum + 48'(itm_r.cycle_count);
    rec_stats.min  = (itm_r.cycle_count < stats_rd_r.min) ? itm_r.cycle_count : stats_rd_r.min;
    rec_stats.max  = (itm_r.cycle_count > stats_rd_r.max) ? itm_r.cycle_count : stats_rd_r.max;
  end

  always_comb begin
    res = '0;
    reg_ok = 1'b0;
    rec_ok = 1'b0;
    count_nxt = count_r;
    total_nxt = total_r;
    coll_nxt = coll_r;
    unique case (itm_r.opcode)
      OP_REGISTER: begin
        if (!enable) begin
          res.status = ST_NOT_ENABLED;
        end else if (count_r == CNT_W'(MAX_POINTS)) begin
          res.status = ST_FULL;
        end else begin
          reg_ok = 1'b1;
          res.result_index = count_ext[5:0];
          count_nxt = count_r + 1'b1;
        end
      end
      OP_RECORD: begin
        res.result_index = itm_r.point_index;
        if (!enable) begin
          res.status = ST_NOT_ENABLED;
        end else if (!coll_r) begin
          res.status = ST_NOT_ON;
        end else if (!idx_ok) begin
          res.status = ST_BAD_INDEX;
        end else begin
          rec_ok = 1'b1;
          total_nxt = total_r + 32'd1;
        end
      end
      OP_QUERY: begin
        res.result_index = itm_r.point_index;
        if (!idx_ok) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.hit_total   = stats_rd_r.hits;
          res.cyc_sum     = stats_rd_r.sum;
          res.cyc_min     = stats_rd_r.min;
          res.cyc_max     = stats_rd_r.max;
          res.stored_type = tl_rd_r.ptype;
          res.stored_line = tl_rd_r.line;
        end
      end
      OP_CLEAR: begin
        total_nxt = 32'd0;
      end
      OP_START: begin
        if (!enable) begin
          res.status = ST_NOT_ENABLED;
        end else if (coll_r) begin
          res.status = ST_ALREADY_ON;
        end else begin
          coll_nxt = 1'b1;
          total_nxt = 32'd0;
        end
      end
      OP_STOP: begin
        if (!enable) begin
          res.status = ST_NOT_ENABLED;
        end else if (!coll_r) begin
          res.status = ST_NOT_ON;
        end else begin
          coll_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.sample_sum = total_nxt;
  end

  // Clear sweep walks entries below the registered count, one per cycle.
  assign sweep_we       = cmd.sweep_step && (sweep_ctr_r < count_r);
  assign sweep_next_cnt = {1'b0, sweep_ctr_r} + 1'b1;
  assign sweep_ctr_nxt  = cmd.sweep_init ? '0 :
                          (cmd.sweep_step ? sweep_next_cnt[CNT_W-1:0] : sweep_ctr_r);

  always_comb begin
    st_we    = sweep_we || (cmd.commit && (reg_ok || rec_ok));
    tl_we    = cmd.commit && reg_ok;
    st_wdata = rec_ok && !sweep_we ? rec_stats : STATS_CLEAR;
    if (sweep_we) begin
      wr_addr = sweep_ctr_r[ADDR_W-1:0];
    end else if (reg_ok) begin
      wr_addr = count_r[ADDR_W-1:0];
    end else begin
      wr_addr = itm_idx_ext[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stats_mem[wr_addr] <= st_wdata;
    end
    if (tl_we) begin
      tl_mem[wr_addr] <= '{ptype: itm_r.point_type, line: itm_r.src_line};
    end
    if (cmd.capture) begin
      stats_rd_r <= stats_mem[rd_addr];
      tl_rd_r    <= tl_mem[rd_addr];
      itm_r      <= in_data;
    end
  end

  assign stat.is_clear   = (itm_r.opcode == OP_CLEAR);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.sweep_done = sweep_next_cnt >= {1'b0, count_r};

  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_nxt = res;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
      coll_r      <= 1'b0;
      sweep_ctr_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sweep_ctr_r <= sweep_ctr_nxt;
      if (cmd.commit) begin
        count_r <= count_nxt;
        total_r <= total_nxt;
        coll_r  <= coll_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/ppst_ctrl.sv
`timescale 1ns / 1ps
module ppst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppst_pkg::dp_stat_t  stat,
  output ppst_pkg::ctrl_cmd_t cmd
);
  import ppst_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_clear) begin
          state_nxt = S_SWEEP;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (stat.sweep_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.sweep_init = stat.is_clear;
        cmd.commit     = !stat.is_clear && stat.out_free;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
      end
      S_FINISH: begin
        cmd.commit = stat.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/profile_point_stats_table.sv
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// in_       in_valid / in_ready          in_data (ppst_pkg::in_item_t)
// out_      out_valid / out_ready        out_data (ppst_pkg::out_item_t)
// cfg_      APB write/read, pready high  cfg_pwdata / cfg_prdata, 32 bits
//
// Each item is accepted and its table entry read in the idle state, then that
// entry is updated and the result register loaded in the execute state. Clear
// instead rewrites the registered entries in the sweep state, through the single
// write port, and loads its result register in the finish state.
// Reset is synchronous and active low; the table contents are not cleared.
// A result waiting in the output register stalls the next item only at its end.
`include "profile_point_stats_table_defines.svh"
module profile_point_stats_table #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ppst_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import ppst_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      enable_r, enable_nxt;
  logic      cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == CFG_IDX_ENABLE);
  assign cfg_prdata = cfg_hit ? {31'd0, enable_r} : 32'd0;

  always_comb begin
    enable_nxt = enable_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      enable_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  ppst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppst_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .enable    (enable_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Only one item is in flight at a time.
  `PPST_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // A result never overwrites one that has not been taken.
  `PPST_ASSERT_SAME(a_commit_free, cmd.commit, stat.out_free)
  // A new result appears only right after a commit.
  `PPST_ASSERT_SAME(a_out_from_commit, $rose(out_valid), $past(cmd.commit))

endmodule

FILE: dv/point_stats_checker.sv
`timescale 1ns / 1ps
module point_stats_checker #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ppst_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ppst_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_pready,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output int                  mismatches,
  output int                  outstanding
);
  import ppst_pkg::*;

  localparam logic [2:0] ENABLE_ADDR = 3'(CFG_IDX_ENABLE) << 2;

  // Shadow copy of the point table and its control state.
  logic [31:0] hits_tbl  [MAX_POINTS];
  logic [47:0] sum_tbl   [MAX_POINTS];
  logic [31:0] min_tbl   [MAX_POINTS];
  logic [31:0] max_tbl   [MAX_POINTS];
  logic [2:0]  ptype_tbl [MAX_POINTS];
  logic [15:0] line_tbl  [MAX_POINTS];
  int          n_registered;
  logic [31:0] samples_total;
  logic        collecting;
  logic        enabled;

  out_item_t   pending_replies[$];
  int          err_total = 0;

  function automatic void wipe_stats(input int i);
    hits_tbl[i] = '0;
    sum_tbl[i]  = '0;
    min_tbl[i]  = '1;
    max_tbl[i]  = '0;
  endfunction

  // Applies one item to the shadow table and returns the reply it must produce.
  function automatic out_item_t point_table_op(input in_item_t it);
    out_item_t r;
    int        idx;
    r   = '0;
    idx = int'(it.point_index);
    case (it.opcode)
      OP_REGISTER: begin
        if (!enabled) begin
          r.status = ST_NOT_ENABLED;
        end else if (n_registered >= MAX_POINTS) begin
          r.status = ST_FULL;
        end else begin
          ptype_tbl[n_registered] = it.point_type;
          line_tbl[n_registered]  = it.src_line;
          wipe_stats(n_registered);
          r.result_index = 6'(n_registered);
          n_registered++;
        end
      end
      OP_RECORD: begin
        r.result_index = it.point_index;
        if (!enabled) begin
          r.status = ST_NOT_ENABLED;
        end else if (!collecting) begin
          r.status = ST_NOT_ON;
        end else if (idx >= n_registered) begin
          r.status = ST_BAD_INDEX;
        end else begin
          hits_tbl[idx] = hits_tbl[idx] + 32'd1;
          sum_tbl[idx]  = sum_tbl[idx] + 48'(it.cycle_count);
          if (it.cycle_count < min_tbl[idx]) min_tbl[idx] = it.cycle_count;
          if (it.cycle_count > max_tbl[idx]) max_tbl[idx] = it.cycle_count;
          samples_total = samples_total + 32'd1;
        end
      end
      OP_QUERY: begin
        r.result_index = it.point_index;
        if (idx >= n_registered) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.hit_total   = hits_tbl[idx];
          r.cyc_sum     = sum_tbl[idx];
          r.cyc_min     = min_tbl[idx];
          r.cyc_max     = max_tbl[idx];
          r.stored_type = ptype_tbl[idx];
          r.stored_line = line_tbl[idx];
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < n_registered; i++) wipe_stats(i);
        samples_total = '0;
      end
      OP_START: begin
        if (!enabled) begin
          r.status = ST_NOT_ENABLED;
        end else if (collecting) begin
          r.status = ST_ALREADY_ON;
        end else begin
          collecting    = 1'b1;
          samples_total = '0;
        end
      end
      OP_STOP: begin
        if (!enabled) r.status = ST_NOT_ENABLED;
        else if (!collecting) r.status = ST_NOT_ON;
        else collecting = 1'b0;
      end
      default: begin
      end
    endcase
    r.sample_sum = samples_total;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      n_registered  = 0;
      samples_total = '0;
      collecting    = 1'b0;
      enabled       = 1'b0;
      pending_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result with nothing expected, expected none actual %h",
                   $time, out_data);
          err_total++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("result_index", want.result_index, out_data.result_index);
          check_field("hit_total", want.hit_total, out_data.hit_total);
          check_field("cyc_sum", want.cyc_sum, out_data.cyc_sum);
          check_field("cyc_min", want.cyc_min, out_data.cyc_min);
          check_field("cyc_max", want.cyc_max, out_data.cyc_max);
          check_field("stored_type", want.stored_type, out_data.stored_type);
          check_field("stored_line", want.stored_line, out_data.stored_line);
          check_field("sample_sum", want.sample_sum, out_data.sample_sum);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ENABLE_ADDR)
        enabled = cfg_pwdata[0];
      if (in_valid && in_ready) pending_replies.push_back(point_table_op(in_data));
    end
    outstanding <= pending_replies.size();
    mismatches  <= err_total;
  end

endmodule

FILE: dv/tb_profile_point_stats_table.sv
`timescale 1ns / 1ps
module tb_profile_point_stats_table;
  import ppst_pkg::*;

  localparam int         POINTS      = 64;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam logic [2:0] ENABLE_ADDR = 3'(CFG_IDX_ENABLE) << 2;
  localparam int         LONG_HOLD   = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int outstanding;

  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  int   long_hold_count    = 0;
  int   regs_sent          = 0;
  logic enable_on          = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  profile_point_stats_table u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  point_stats_checker #(.MAX_POINTS(POINTS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic in_item_t op_item(input logic [2:0] op, input logic [5:0] idx,
                                       input logic [31:0] cyc, input logic [2:0] typ,
                                       input logic [15:0] line);
    in_item_t it;
    it.opcode      = op;
    it.point_index = idx;
    it.cycle_count = cyc;
    it.point_type  = typ;
    it.src_line    = line;
    return it;
  endfunction

  // Mostly records against points that exist, with a sprinkling of everything else.
  function automatic in_item_t random_op();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) it.opcode = OP_REGISTER;
    else if (pick < 10) it.opcode = ($urandom_range(1) != 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    else if (pick < 13) it.opcode = OP_CLEAR;
    else if (pick < 18) it.opcode = OP_START;
    else if (pick < 20) it.opcode = OP_STOP;
    else if (pick < 40) it.opcode = OP_QUERY;
    else it.opcode = OP_RECORD;
    if (regs_sent > 0 && $urandom_range(99) < 85)
      it.point_index = 6'($urandom_range(regs_sent - 1));
    else
      it.point_index = 6'($urandom_range(63));
    case ($urandom_range(9))
      0:       it.cycle_count = '0;
      1:       it.cycle_count = '1;
      2:       it.cycle_count = 32'd1 << $urandom_range(31);
      default: it.cycle_count = $urandom;
    endcase
    it.point_type = 3'($urandom_range(7));
    it.src_line   = 16'($urandom_range(16'hFFFF));
    return it;
  endfunction

  // Leaves in_valid high after acceptance; the next call or drain() decides what follows.
  task automatic push_op(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.opcode == OP_REGISTER && enable_on && regs_sent < POINTS) regs_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_enable(input logic on);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ENABLE_ADDR;
    cfg_pwdata  <= 32'(on);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    enable_on = on;
  endtask

  // Receiver: random stalls, plus one long hold-off whenever the stimulus asks for it.
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != long_hold_count) begin
        holds_seen = long_hold_count;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled: only query, clear and the unused codes go through.
    push_op(op_item(OP_REGISTER, 6'd0, 32'd0, 3'd5, 16'h1234));
    push_op(op_item(OP_RECORD, 6'd0, 32'd7, 3'd0, 16'd0));
    push_op(op_item(OP_START, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_STOP, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_QUERY, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_CLEAR, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_UNUSED_6, 6'h3F, '1, 3'd7, 16'hFFFF));
    push_op(op_item(OP_UNUSED_7, 6'h2A, 32'h5555_AAAA, 3'd2, 16'hA5A5));
    drain();
    write_enable(1'b1);

    push_op(op_item(OP_RECORD, 6'd0, 32'd9, 3'd0, 16'd0));
    push_op(op_item(OP_STOP, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_REGISTER, 6'h3F, '1, 3'd7, 16'hFFFF));
    push_op(op_item(OP_REGISTER, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_START, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_START, 6'd0, 32'd0, 3'd0, 16'd0));
    // An all-ones sample on a fresh point must leave its minimum at all ones.
    push_op(op_item(OP_RECORD, 6'd1, '1, 3'd0, 16'd0));
    push_op(op_item(OP_RECORD, 6'd0, '1, 3'd0, 16'd0));
    push_op(op_item(OP_RECORD, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_RECORD, 6'h3F, 32'd5, 3'd0, 16'd0));
    push_op(op_item(OP_QUERY, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_QUERY, 6'd1, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_QUERY, 6'h3F, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_CLEAR, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_QUERY, 6'd0, 32'd0, 3'd0, 16'd0));
    drain();
    write_enable(1'b0);

    // Collecting stays set while disabled, so stop is refused until enable returns.
    push_op(op_item(OP_STOP, 6'd0, 32'd0, 3'd0, 16'd0));
    push_op(op_item(OP_RECORD, 6'd1, 32'd3, 3'd0, 16'd0));
    push_op(op_item(OP_QUERY, 6'd1, 32'd0, 3'd0, 16'd0));
    drain();
    write_enable(1'b1);
    push_op(op_item(OP_STOP, 6'd0, 32'd0, 3'd0, 16'd0));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_enable(!(ph == 2 || ph == 7));
      case (ph % 4)
        0: begin
          sender_idle_pct    <= 0;
          receiver_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct    <= 53;
          receiver_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct    <= 0;
          receiver_stall_pct <= 53;
        end
        default: begin
          sender_idle_pct    <= 31;
          receiver_stall_pct <= 31;
        end
      endcase
      // The sender keeps pushing through the hold-off so the block backs up.
      if (ph == 0) long_hold_count <= long_hold_count + 1;
      repeat (175) push_op(random_op());
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
